[hdl/cma_pkg.sv]
// ----------------------------------------------------------------------------
// cma_pkg
// Shared widths, codes and types of the centered moving average filter bank.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int MAX_HALF = 16;
   localparam int SAMPLE_W = 16;
   localparam int DEPTH    = 2 * MAX_HALF + 1;
   localparam int HALF_W   = 5;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int MAG_W    = SUM_W - 1;
   localparam int MODE_W   = 2;
   localparam int IDX_W    = 2;

   localparam logic [MODE_W-1:0] MODE_LOW  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HIGH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BAND = 2'd2;

   localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [IDX_W-1:0] REG_SINGLE = 2'd1;
   localparam logic [IDX_W-1:0] REG_SMOOTH = 2'd2;
   localparam logic [IDX_W-1:0] REG_TREND  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_START,
      ST_DIV,
      ST_HOLD
   } stage_state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic scan;
   } cell_ctl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] avg;
      logic signed [SAMPLE_W-1:0] ctr;
      logic                       last;
   } stage_res_type;

endpackage

[hdl/cma_cell.sv]
// ----------------------------------------------------------------------------
// cma_cell
// One tap of the delay line plus one slot of the scan chain that feeds the sum.
// ----------------------------------------------------------------------------
module cma_cell (
   input  logic                            clock,
   input  cma_pkg::cell_ctl_type           ctl,
   input  logic [cma_pkg::SAMPLE_W-1:0]    tap_prev,
   input  logic [cma_pkg::SAMPLE_W-1:0]    scan_next,
   output logic [cma_pkg::SAMPLE_W-1:0]    tap,
   output logic [cma_pkg::SAMPLE_W-1:0]    scan
);
   import cma_pkg::*;

   logic [SAMPLE_W-1:0] tap_ff, tap_in;
   logic [SAMPLE_W-1:0] scan_ff, scan_in;

   always_comb begin
      tap_in  = ctl.shift ? tap_prev : tap_ff;
      scan_in = scan_ff;
      if (ctl.load) begin
         scan_in = tap_ff;
      end else if (ctl.scan) begin
         scan_in = scan_next;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      scan_ff <= scan_in;
   end

   assign tap  = tap_ff;
   assign scan = scan_ff;

endmodule

[hdl/cma_div.sv]
// ----------------------------------------------------------------------------
// cma_div
// Serial restoring divider: window sum by sample count, truncating to zero.
// ----------------------------------------------------------------------------
module cma_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cma_pkg::SUM_W-1:0]    dividend,
   input  logic [cma_pkg::CNT_W-1:0]           divisor,
   output logic                                done,
   output logic signed [cma_pkg::SAMPLE_W-1:0] quotient
);
   import cma_pkg::*;

   localparam int STEP_W = $clog2(MAG_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  quo_ff, quo_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  div_ff, div_in;

   logic [SUM_W-1:0]  abs_val;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    rem_sub;
   logic              ge;
   logic [MAG_W-1:0]  q_signed;

   always_comb begin
      abs_val = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      rem_sh  = {rem_ff, quo_ff[MAG_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      ge      = rem_sh >= {1'b0, div_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(MAG_W);
         rem_in  = '0;
         quo_in  = abs_val[MAG_W-1:0];
         neg_in  = dividend[SUM_W-1];
         div_in  = divisor;
      end else if (busy_ff) begin
         step_in = step_ff - STEP_W'(1);
         rem_in  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in  = {quo_ff[MAG_W-2:0], ge};
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
   end

   assign q_signed = neg_ff ? (~quo_ff + MAG_W'(1)) : quo_ff;
   assign quotient = q_signed[SAMPLE_W-1:0];
   assign done     = done_ff;

endmodule

[hdl/cma_stage.sv]
// ----------------------------------------------------------------------------
// cma_stage
// One centered moving average: a chain of tap cells, a serial window sum and
// a serial divider, emitting (mean, center) pairs one at a time.
// ----------------------------------------------------------------------------
module cma_stage (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clr_seen,
   input  logic [cma_pkg::HALF_W-1:0]          half,
   input  logic                                push_valid,
   input  logic [cma_pkg::SAMPLE_W-1:0]        push_sample,
   input  logic                                push_last,
   output logic                                push_ready,
   output logic                                res_valid,
   output cma_pkg::stage_res_type              res,
   input  logic                                res_ready
);
   import cma_pkg::*;

   stage_state_type state_ff, state_in;

   logic [CNT_W-1:0]    seen_ff, seen_in;
   logic [HALF_W-1:0]   p_ff, p_in;
   logic                last_ff, last_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic signed [SUM_W-1:0] acc_ff, acc_in;
   logic [SAMPLE_W-1:0] ctr_ff, ctr_in;

   cell_ctl_type        ctl;
   logic [SAMPLE_W-1:0] tap  [DEPTH];
   logic [SAMPLE_W-1:0] scan [DEPTH];

   logic [CNT_W-1:0]    seen_sat;
   logic [CNT_W-1:0]    half_ext;
   logic [CNT_W-1:0]    p_ext;
   logic [CNT_W-1:0]    newer;
   logic [CNT_W-1:0]    older;
   logic                res_done;
   logic                div_start;
   logic                div_done;
   logic signed [SAMPLE_W-1:0] div_q;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [SAMPLE_W-1:0] prev_w;
         logic [SAMPLE_W-1:0] next_w;
         if (gi == 0) begin : g_head
            assign prev_w = push_sample;
         end else begin : g_body
            assign prev_w = tap[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign next_w = '0;
         end else begin : g_link
            assign next_w = scan[gi+1];
         end
         cma_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .tap_prev  (prev_w),
            .scan_next (next_w),
            .tap       (tap[gi]),
            .scan      (scan[gi])
         );
      end
   endgenerate

   cma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      seen_sat = (seen_ff == CNT_W'(DEPTH)) ? seen_ff : seen_ff + CNT_W'(1);
      half_ext = CNT_W'(half);
      p_ext    = CNT_W'(p_ff);
      newer    = seen_ff - CNT_W'(1) - p_ext;
      older    = (newer > half_ext) ? half_ext : newer;
      res_done = res_ready && (state_ff == ST_HOLD);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (push_valid && (seen_sat > half_ext || push_last)) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (k_ff == cnt_ff - CNT_W'(1)) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (res_ready) begin
               state_in = (last_ff && p_ff != '0) ? ST_LOAD : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl.shift  = (state_ff == ST_IDLE) && push_valid;
      ctl.load   = (state_ff == ST_LOAD);
      ctl.scan   = (state_ff == ST_SCAN);
      div_start  = (state_ff == ST_START);
      push_ready = (state_ff == ST_IDLE);
      res_valid  = (state_ff == ST_HOLD);
      res.avg    = div_q;
      res.ctr    = ctr_ff;
      res.last   = last_ff && (p_ff == '0);
   end

   always_comb begin
      seen_in = seen_ff;
      p_in    = p_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      ctr_in  = ctr_ff;
      if (clr_seen) begin
         seen_in = '0;
      end else if (ctl.shift) begin
         seen_in = seen_sat;
      end else if (res_done && last_ff && p_ff == '0) begin
         seen_in = '0;
      end
      if (ctl.shift) begin
         last_in = push_last;
         if (seen_sat > half_ext) begin
            p_in = half;
         end else begin
            p_in = HALF_W'(seen_sat - CNT_W'(1));
         end
      end else if (res_done && last_ff && p_ff != '0) begin
         p_in = p_ff - HALF_W'(1);
      end
      if (ctl.load) begin
         cnt_in = p_ext + CNT_W'(1) + older;
         k_in   = '0;
         acc_in = '0;
      end else if (ctl.scan) begin
         k_in   = k_ff + CNT_W'(1);
         acc_in = acc_ff + SUM_W'(signed'(scan[0]));
         if (k_ff == p_ext) begin
            ctr_in = scan[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
      end
      p_ff    <= p_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      ctr_ff  <= ctr_in;
   end

   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> k_ff < cnt_ff)
      else $error("scan index ran past the window");
   a_center_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> p_ext < cnt_ff)
      else $error("center lies outside the window");
   a_hold_until_taken: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD && !res_ready |=> state_ff == ST_HOLD)
      else $error("result dropped before it was taken");

endmodule

[hdl/centered_moving_average_filter_bank.sv]
// ----------------------------------------------------------------------------
// centered_moving_average_filter_bank
// Low, high and band pass centered moving averages over sample blocks.
// ----------------------------------------------------------------------------
// Each result is computed once the item that completes its window arrives:
// the stage scans the window (count = samples in the window, up to 33) into a
// serial sum and then divides; band pass chains two stages.
// A stage takes no new item while it computes a result. A block end flushes
// up to 16 results per stage serially; the scan of the cell chain and the
// 21-step serial divider set how long each result takes.
// Reset: synchronous; state and settings take defaults, the block starts empty.
// ----------------------------------------------------------------------------
module centered_moving_average_filter_bank (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cma_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_block_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cma_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                rsp_final_res,
   input  logic                                csr_write_enable,
   input  logic [cma_pkg::IDX_W-1:0]           csr_index,
   input  logic [cma_pkg::HALF_W-1:0]          csr_write_data
);
   import cma_pkg::*;

   function automatic logic [HALF_W-1:0] clamp_half(input logic [HALF_W-1:0] h);
      return (h > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : h;
   endfunction

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [HALF_W-1:0] single_ff, single_in;
   logic [HALF_W-1:0] smooth_ff, smooth_in;
   logic [HALF_W-1:0] trend_ff, trend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_final_ff, rsp_final_in;

   logic          band;
   logic [HALF_W-1:0] s1_half;
   logic          s1_push_ready, s1_res_valid, s1_res_ready;
   logic          s2_push_ready, s2_res_valid;
   stage_res_type s1_res, s2_res;
   logic          out_free;

   assign band     = (mode_ff == MODE_BAND);
   assign s1_half  = band ? clamp_half(smooth_ff) : clamp_half(single_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // take a new item only once both stages have drained
   assign req_stall    = !(s1_push_ready && s2_push_ready);
   assign s1_res_ready = band ? s2_push_ready : out_free;

   cma_stage u_smooth (
      .clock       (clock),
      .reset       (reset),
      .clr_seen    (csr_write_enable),
      .half        (s1_half),
      .push_valid  (req_valid && !req_stall),
      .push_sample (req_sample),
      .push_last   (req_block_end),
      .push_ready  (s1_push_ready),
      .res_valid   (s1_res_valid),
      .res         (s1_res),
      .res_ready   (s1_res_ready)
   );

   cma_stage u_trend (
      .clock       (clock),
      .reset       (reset),
      .clr_seen    (csr_write_enable),
      .half        (clamp_half(trend_ff)),
      .push_valid  (s1_res_valid && band),
      .push_sample (s1_res.avg),
      .push_last   (s1_res.last),
      .push_ready  (s2_push_ready),
      .res_valid   (s2_res_valid),
      .res         (s2_res),
      .res_ready   (out_free)
   );

   always_comb begin
      mode_in   = mode_ff;
      single_in = single_ff;
      smooth_in = smooth_ff;
      trend_in  = trend_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_MODE:   mode_in   = csr_write_data[MODE_W-1:0];
            REG_SINGLE: single_in = csr_write_data;
            REG_SMOOTH: smooth_in = csr_write_data;
            REG_TREND:  trend_in  = csr_write_data;
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_final_in = rsp_final_ff;
      if (out_free) begin
         if (band && s2_res_valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = s2_res.ctr - s2_res.avg;
            rsp_final_in = s2_res.last;
         end else if (!band && s1_res_valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = (mode_ff == MODE_HIGH) ? s1_res.ctr - s1_res.avg : s1_res.avg;
            rsp_final_in = s1_res.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LOW;
         single_ff    <= HALF_W'(10);
         smooth_ff    <= HALF_W'(3);
         trend_ff     <= HALF_W'(12);
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         single_ff    <= single_in;
         smooth_ff    <= smooth_in;
         trend_ff     <= trend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_data_ff;
   assign rsp_final_res = rsp_final_ff;

   a_trend_idle_outside_band: assert property (@(posedge clock) disable iff (reset)
      !band |-> s2_push_ready)
      else $error("trend stage busy outside band pass");
   a_item_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !s2_res_valid)
      else $error("trend stage held a result across a new item");
   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=>
         rsp_valid_ff && $stable(rsp_data_ff) && $stable(rsp_final_ff))
      else $error("stalled result changed before it was taken");

endmodule

[test/tb_centered_moving_average_filter_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_centered_moving_average_filter_bank
// Drives sample blocks through all three filter modes and several window
// settings, predicts every filtered sample and checks the result stream.
// ----------------------------------------------------------------------------
class filter_scoreboard;
   typedef struct {
      logic signed [15:0] filtered;
      logic               final_res;
   } filt_res_t;

   logic [1:0] mode;
   logic [4:0] single_half;
   logic [4:0] smooth_half;
   logic [4:0] trend_half;
   longint raw_line[33];
   longint smooth_line[33];
   int     raw_seen;
   int     smooth_seen;
   filt_res_t pending_filtered[$];
   int     errors;
   int     checked;

   function void clear_state();
      mode = cma_pkg::MODE_LOW;
      single_half = 10;
      smooth_half = 3;
      trend_half = 12;
      foreach (raw_line[i]) begin
         raw_line[i] = 0;
         smooth_line[i] = 0;
      end
      raw_seen = 0;
      smooth_seen = 0;
      pending_filtered.delete();
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [4:0] val);
      case (idx)
         cma_pkg::REG_MODE: mode = val[1:0];
         cma_pkg::REG_SINGLE: single_half = val;
         cma_pkg::REG_SMOOTH: smooth_half = val;
         default: trend_half = val;
      endcase
      raw_seen = 0;
      smooth_seen = 0;
   endfunction

   static function longint wrap16(longint v);
      logic signed [15:0] w;
      w = v[15:0];
      return longint'(w);
   endfunction

   // mean of the window centered at line position p, cut at block edges
   static function longint edge_mean(longint line[33], int seen, int p, int h);
      int older;
      int cnt;
      longint sum;
      older = seen - 1 - p;
      if (older > h) older = h;
      cnt = p + 1 + older;
      sum = 0;
      for (int i = 0; i < cnt; i++) sum += line[i];
      return sum / cnt;
   endfunction

   // push one sample into a stage; return (mean, center) pairs in order
   static function void push_stage(ref longint line[33], ref int seen, input int hw,
                                   input longint x, input bit last,
                                   ref longint means[$], ref longint ctrs[$]);
      int h;
      int p;
      h = (hw > 16) ? 16 : hw;
      means.delete();
      ctrs.delete();
      for (int i = 32; i > 0; i--) line[i] = line[i-1];
      line[0] = x;
      if (seen < 33) seen++;
      if (seen > h) begin
         means.push_back(edge_mean(line, seen, h, h));
         ctrs.push_back(line[h]);
      end
      if (last) begin
         p = (seen < h) ? seen : h;
         while (p > 0) begin
            p--;
            means.push_back(edge_mean(line, seen, p, h));
            ctrs.push_back(line[p]);
         end
         seen = 0;
      end
   endfunction

   function void note_sample(logic signed [15:0] s, logic last);
      longint m1[$], c1[$], m2[$], c2[$];
      filt_res_t r;
      int first;
      first = pending_filtered.size();
      if (mode == cma_pkg::MODE_BAND) begin
         push_stage(raw_line, raw_seen, smooth_half, longint'(s), last, m1, c1);
         for (int k = 0; k < m1.size(); k++) begin
            push_stage(smooth_line, smooth_seen, trend_half, m1[k],
                       last && k == m1.size() - 1, m2, c2);
            for (int j = 0; j < m2.size(); j++) begin
               r.filtered = wrap16(c2[j] - m2[j]);
               r.final_res = 0;
               pending_filtered.push_back(r);
            end
         end
      end else begin
         push_stage(raw_line, raw_seen, single_half, longint'(s), last, m1, c1);
         for (int k = 0; k < m1.size(); k++) begin
            r.filtered = (mode == cma_pkg::MODE_HIGH) ? wrap16(c1[k] - m1[k])
                                                      : wrap16(m1[k]);
            r.final_res = 0;
            pending_filtered.push_back(r);
         end
      end
      if (last && pending_filtered.size() > first)
         pending_filtered[pending_filtered.size()-1].final_res = 1;
   endfunction

   function void check_result(logic signed [15:0] f, logic fin);
      filt_res_t e;
      checked++;
      if (pending_filtered.size() == 0) begin
         $display("%0t: unexpected result filtered=%0d final=%0b", $time, f, fin);
         errors++;
         return;
      end
      e = pending_filtered.pop_front();
      if (f !== e.filtered) begin
         $display("%0t: filtered mismatch expected %0d actual %0d",
                  $time, e.filtered, f);
         errors++;
      end
      if (fin !== e.final_res) begin
         $display("%0t: final_res mismatch expected %0b actual %0b",
                  $time, e.final_res, fin);
         errors++;
      end
   endfunction
endclass

module tb_centered_moving_average_filter_bank;
   import cma_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       req_block_end;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_final_res;
   logic                       csr_write_enable;
   logic [IDX_W-1:0]           csr_index;
   logic [HALF_W-1:0]          csr_write_data;

   filter_scoreboard filt_sb;
   int  cycle_count;
   int  samples_sent;
   bit  drain_sink;
   localparam int CYCLE_LIMIT = 2000000;

   centered_moving_average_filter_bank dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall)
         filt_sb.check_result(rsp_filtered, rsp_final_res);
   end

   // result-side stall, random gaps; stretches with no stall while draining
   initial begin
      int g;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         g = drain_sink ? 0 : gap_len();
         if (g > 0) begin
            rsp_stall = 1'b1;
            repeat (g) @(negedge clock);
            rsp_stall = 1'b0;
         end
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   end

   task automatic send_sample(logic signed [15:0] s, logic last);
      repeat (gap_len()) @(negedge clock);
      req_sample = s;
      req_block_end = last;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filt_sb.note_sample(s, last);
      samples_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (filt_sb.pending_filtered.size() != 0) @(negedge clock);
      // a sample that completes no window may still be in flight
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [HALF_W-1:0] val);
      wait_idle();
      csr_index = idx;
      csr_write_data = val;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      filt_sb.write_reg(idx, val);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return $urandom_range(0, 40) - 20;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_block(int len);
      for (int i = 0; i < len; i++)
         send_sample(rand_sample(), i == len - 1);
   endtask

   initial begin
      int len;
      filt_sb = new();
      filt_sb.clear_state();
      cycle_count = 0;
      samples_sent = 0;
      drain_sink = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_block_end = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = REG_MODE;
      csr_write_data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: reset windows, extremes, one-sample block, half window zero
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'shFFFF, 1'b1);
      send_sample(16'sh1234, 1'b1);
      write_csr(REG_MODE, MODE_HIGH);
      write_csr(REG_SINGLE, 5'd0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      write_csr(REG_MODE, MODE_LOW);
      send_sample(16'sh8000, 1'b1);
      write_csr(REG_SINGLE, 5'd31);
      write_csr(REG_MODE, 2'd3);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      // a write inside a block drops what is pending
      write_csr(REG_MODE, MODE_HIGH);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      write_csr(REG_MODE, MODE_BAND);
      write_csr(REG_SMOOTH, 5'd0);
      write_csr(REG_TREND, 5'd31);
      send_block(4);
      write_csr(REG_SMOOTH, 5'd16);
      write_csr(REG_TREND, 5'd0);
      send_block(5);

      // random phases of settings and blocks
      while (samples_sent < 440) begin
         case ($urandom_range(0, 3))
            0: write_csr(REG_MODE, $urandom_range(0, 3));
            1: write_csr(REG_SINGLE, $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 31) : $urandom_range(0, 6));
            2: write_csr(REG_SMOOTH, $urandom_range(0, 4) == 0 ?
                         $urandom_range(0, 31) : $urandom_range(0, 4));
            default: write_csr(REG_TREND, $urandom_range(0, 4) == 0 ?
                               $urandom_range(0, 31) : $urandom_range(0, 8));
         endcase
         repeat ($urandom_range(1, 3)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45)
                                              : $urandom_range(1, 12);
            send_block(len);
            // occasionally hold the sender until all results are back
            if ($urandom_range(0, 5) == 0)
               while (filt_sb.pending_filtered.size() != 0) @(negedge clock);
         end
         // sometimes leave a block open so the next write cuts it off
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) send_sample(rand_sample(), 1'b0);
      end

      drain_sink = 1;
      wait_idle();
      $display("Covered %0d samples and %0d results over low, high and band pass",
               samples_sent, filt_sb.checked);
      $display("with half windows from zero through above the maximum.");
      if (filt_sb.errors == 0 && filt_sb.pending_filtered.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
